// File: hdl/qtyd_pkg.sv
// qtyd_pkg: widths, angle constants, arctangent table and the word type shared
// by all stages of the quaternion-to-yaw pipeline. No dependencies.
package qtyd_pkg;

  localparam int IN_W      = 16;  // one quaternion component, Q2.14
  localparam int NUM_W     = 34;  // exact numerator / denominator, LSB 2^-28
  localparam int XW        = 37;  // CORDIC vector, with headroom for gain
  localparam int ZW        = 33;  // angle accumulator, LSB 2^-16 centidegree
  localparam int OUT_W     = 16;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [ZW-1:0]    ANGLE_180 = 33'sd1179648000;
  localparam logic signed [OUT_W-1:0] YAW_MAX   = 16'sd18000;
  localparam logic signed [OUT_W-1:0] YAW_MIN   = -16'sd18000;
  localparam logic [NUM_W-1:0]        ONE_Q28   = 34'd268435456;

  // atan(2^-i) in 2^-16 centidegree units
  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
    32'd23437865,  32'd11730358,  32'd5866609,  32'd2933484,
    32'd1466766,   32'd733385,    32'd366693,   32'd183347,
    32'd91673,     32'd45837,     32'd22918,    32'd11459,
    32'd5730,      32'd2865,      32'd1432,     32'd716,
    32'd358,       32'd179,       32'd90,       32'd45
  };

  // one word in flight through the rotation chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 bypass;      // numerator was zero: fixed result
    logic                 bypass_neg;  // ...and denominator negative
  } qtyd_vec_t;

endpackage

// File: hdl/quaternion_to_yaw_degrees_core.sv
// quaternion_to_yaw_degrees_core: top level of the quaternion-to-yaw pipeline.
// Depends on qtyd_pkg, qtyd_prep, qtyd_cordic_cell, qtyd_round.
//
// Usage:
//   in_*  : one word per quaternion, four signed Q2.14 components.
//   out_* : one word per quaternion, the negated heading -atan2(num, den)
//           in hundredths of a degree, limited to -18000..18000, where
//           num = 2(wz+xy) and den = 1-2(y^2+z^2) are formed exactly.
//   A word is taken on any edge with tvalid and tready both high.
// Timing:
//   Three preparation stages (products, sums, half-plane fold), one cell
//   per micro-rotation, and the rounding stage that is also the output
//   register. Throughput is one word per cycle while out_tready stays high;
//   every stage has its own valid bit and the ready chain lets a stage load
//   whenever it is empty or draining.
// Stall: when out_tready is low the result holds and the words behind it
//   keep moving into empty stages; in_tready drops only once every stage
//   is full. Reset clears all valid bits; nothing else is kept.
module quaternion_to_yaw_degrees_core #(
  parameter int CORDIC_STEPS = qtyd_pkg::CORDIC_STEPS_DEF   // 8..24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata    // yaw_centidegrees[15:0]
);

  localparam int NCELLS = (CORDIC_STEPS > qtyd_pkg::TABLE_LEN) ?
                          qtyd_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int IW     = qtyd_pkg::IN_W;

  // chain taps: index 0 is the prep output, NCELLS feeds the rounding stage
  qtyd_pkg::qtyd_vec_t chain_vec   [NCELLS+1];
  logic                chain_valid [NCELLS+1];
  logic                chain_ready [NCELLS+1];
  logic signed [qtyd_pkg::OUT_W-1:0] yaw;

  qtyd_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .quat_w    ($signed(in_tdata[IW-1:0])),
    .quat_x    ($signed(in_tdata[2*IW-1:IW])),
    .quat_y    ($signed(in_tdata[3*IW-1:2*IW])),
    .quat_z    ($signed(in_tdata[4*IW-1:3*IW])),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_vec   (chain_vec[0])
  );

  // one micro-rotation per cell, shift and table entry fixed by position
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    qtyd_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_vec    (chain_vec[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_vec   (chain_vec[i+1])
    );
  end

  qtyd_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[NCELLS]),
    .in_ready  (chain_ready[NCELLS]),
    .in_vec    (chain_vec[NCELLS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .yaw       (yaw)
  );

  assign out_tdata = yaw;

  // result always inside the limited range
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= qtyd_pkg::YAW_MAX &&
                    $signed(out_tdata) >= qtyd_pkg::YAW_MIN))
    else $error("yaw out of range");

  // an empty output stage means every stage can load
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output stage empty");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a word can only reach an idle output from the last cell of the chain
  a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !in_tvalid) |=> !out_tvalid || $past(chain_valid[NCELLS]))
    else $error("word skipped a stage");

endmodule

// File: hdl/qtyd_prep.sv
// qtyd_prep: three register stages ahead of the rotation chain: products,
// exact numerator / denominator, half-plane fold and zero-numerator detect.
// Depends on qtyd_pkg.
module qtyd_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qtyd_pkg::IN_W-1:0]    quat_w,
  input  logic signed [qtyd_pkg::IN_W-1:0]    quat_x,
  input  logic signed [qtyd_pkg::IN_W-1:0]    quat_y,
  input  logic signed [qtyd_pkg::IN_W-1:0]    quat_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output qtyd_pkg::qtyd_vec_t                 out_vec
);

  localparam int PW = 2 * qtyd_pkg::IN_W;
  localparam int NW = qtyd_pkg::NUM_W;
  localparam int XW = qtyd_pkg::XW;

  logic va_r, vb_r, vc_r;
  logic va_nxt, vb_nxt, vc_nxt;
  logic rdy_a, rdy_b, rdy_c;

  logic signed [PW-1:0] wz_r, xy_r, yy_r, zz_r;
  logic signed [NW-1:0] num_r, den_r;
  logic signed [NW-1:0] num_nxt, den_nxt;
  logic signed [PW:0]   sum_cross, sum_sq;
  qtyd_pkg::qtyd_vec_t  vec_r, vec_nxt;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    va_nxt = rdy_a ? in_valid : va_r;
    vb_nxt = rdy_b ? va_r : vb_r;
    vc_nxt = rdy_c ? vb_r : vc_r;
  end

  // stage B: exact sums, doubled
  always_comb begin
    sum_cross = (PW+1)'(wz_r) + (PW+1)'(xy_r);
    sum_sq    = (PW+1)'(yy_r) + (PW+1)'(zz_r);
    num_nxt   = NW'(sum_cross) <<< 1;
    den_nxt   = $signed(qtyd_pkg::ONE_Q28) - (NW'(sum_sq) <<< 1);
  end

  // stage C: fold left half-plane by 180 degrees
  always_comb begin
    vec_nxt            = '0;
    vec_nxt.bypass     = (num_r == '0);
    vec_nxt.bypass_neg = den_r[NW-1];
    if (den_r[NW-1]) begin
      vec_nxt.x = -XW'(den_r);
      vec_nxt.y = -XW'(num_r);
      vec_nxt.z = num_r[NW-1] ? -qtyd_pkg::ANGLE_180 : qtyd_pkg::ANGLE_180;
    end else begin
      vec_nxt.x = XW'(den_r);
      vec_nxt.y = XW'(num_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      wz_r <= quat_w * quat_z;
      xy_r <= quat_x * quat_y;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
    end
    if (rdy_b) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (rdy_c) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_vec   = vec_r;

endmodule

// File: hdl/qtyd_cordic_cell.sv
// qtyd_cordic_cell: one vectoring micro-rotation with its own word register.
// Depends on qtyd_pkg.
module qtyd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qtyd_pkg::qtyd_vec_t in_vec,
  output logic                out_valid,
  input  logic                out_ready,
  output qtyd_pkg::qtyd_vec_t out_vec
);

  localparam int XW = qtyd_pkg::XW;
  localparam int ZW = qtyd_pkg::ZW;
  localparam logic signed [ZW-1:0] ANG = $signed({1'b0, qtyd_pkg::ATAN_TABLE[STEP]});

  logic                 valid_r, valid_nxt;
  logic signed [XW-1:0] xi, yi, xs, ys;
  qtyd_pkg::qtyd_vec_t  vec_r, vec_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    xi      = in_vec.x;
    yi      = in_vec.y;
    xs      = xi >>> STEP;
    ys      = yi >>> STEP;
    vec_nxt = in_vec;
    if (!yi[XW-1]) begin
      vec_nxt.x = xi + ys;
      vec_nxt.y = yi - xs;
      vec_nxt.z = in_vec.z + ANG;
    end else begin
      vec_nxt.x = xi - ys;
      vec_nxt.y = yi + xs;
      vec_nxt.z = in_vec.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// File: hdl/qtyd_round.sv
// qtyd_round: output register; rounds the angle to centidegrees, negates,
// limits to +/-18000 and applies the zero-numerator results. Depends on qtyd_pkg.
module qtyd_round (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  qtyd_pkg::qtyd_vec_t                 in_vec,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qtyd_pkg::OUT_W-1:0]   yaw
);

  localparam int ZW = qtyd_pkg::ZW;
  localparam int RW = ZW - 15;   // rounded magnitude plus sign
  localparam int OW = qtyd_pkg::OUT_W;

  logic                 valid_r, valid_nxt;
  logic [ZW-1:0]        mag;
  logic [ZW:0]          mag_rnd;
  logic signed [RW-1:0] r, res;
  logic signed [OW-1:0] yaw_r, yaw_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_comb begin
    mag     = in_vec.z[ZW-1] ? ZW'(-in_vec.z) : ZW'(in_vec.z);
    mag_rnd = {1'b0, mag} + (ZW+1)'(32768);          // ties away from zero
    r       = $signed({1'b0, mag_rnd[ZW-1:16]});     // magnitude stays below 2^32
    res     = in_vec.z[ZW-1] ? r : -r;               // negated heading
    if (in_vec.bypass) begin
      yaw_nxt = in_vec.bypass_neg ? qtyd_pkg::YAW_MIN : '0;
    end else if (res > RW'(qtyd_pkg::YAW_MAX)) begin
      yaw_nxt = qtyd_pkg::YAW_MAX;
    end else if (res < RW'(qtyd_pkg::YAW_MIN)) begin
      yaw_nxt = qtyd_pkg::YAW_MIN;
    end else begin
      yaw_nxt = OW'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      yaw_r <= yaw_nxt;
    end
  end

  assign out_valid = valid_r;
  assign yaw       = yaw_r;

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for quaternion_to_yaw_degrees_core.
// Streams random and corner quaternions, predicts each heading with an in-bench
// CORDIC model and checks every output word in order. Needs only the RTL and qtyd_pkg.
module tb_top;

  localparam int          STEPS       = 16;      // CORDIC micro-rotations in the dut
  localparam int          LATENCY     = STEPS + 4;
  localparam int          RAND_WORDS  = 700;
  localparam int          CALM_WORDS  = 100;     // tail with no idling on either side
  localparam int          CYCLE_LIMIT = 200000;
  localparam longint      HALF_TURN   = 64'sd1179648000;  // 180 deg, LSB 2^-16 centidegree
  localparam logic signed [15:0] YAW_LIMIT = 16'sd18000;

  // atan(2^-i), LSB 2^-16 centidegree
  localparam longint ATAN_STEP [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866609, 2933484, 1466766, 733385, 366693, 183347,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  // w in the lowest bits, as on in_tdata
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;    // quat_w, quat_x, quat_y, quat_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // yaw_centidegrees

  quat_t                quat_pending [$];
  logic signed [15:0]   yaw_expected [$];
  int                   total_words  = 0;
  int                   words_sent   = 0;
  int                   words_seen   = 0;
  int                   mismatches   = 0;
  int                   cycle_count  = 0;
  int                   in_gap       = 0;
  int                   out_gap      = 0;
  logic                 calm;

  quaternion_to_yaw_degrees_core #(.CORDIC_STEPS(STEPS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  assign calm = (words_sent + CALM_WORDS >= total_words);

  // -heading in centidegrees: exact num/den, CORDIC vectoring, round, clamp
  function automatic logic signed [15:0] yaw_from_quat(quat_t q);
    longint w, x, y, z, num, den, vx, vy, ang, sx, sy, mag, r;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    num = 2 * (w * z + x * y);
    den = (64'sd1 <<< 28) - 2 * (y * y + z * z);
    if (num == 0)
      return (den < 0) ? -YAW_LIMIT : 16'sd0;
    // left half-plane: turn by 180 deg first
    if (den < 0) begin
      vx  = -den;
      vy  = -num;
      ang = (num >= 0) ? HALF_TURN : -HALF_TURN;
    end else begin
      vx  = den;
      vy  = num;
      ang = 0;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        ang = ang + ATAN_STEP[i];
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        ang = ang - ATAN_STEP[i];
      end
    end
    // nearest centidegree, ties away from zero, then negate
    mag = (ang < 0) ? -ang : ang;
    r = (mag + 32768) >>> 16;
    if (ang < 0)
      r = -r;
    r = -r;
    if (r > 18000)
      r = 18000;
    if (r < -18000)
      r = -18000;
    return 16'(r);
  endfunction

  task automatic add_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w);
    q.x = 16'(x);
    q.y = 16'(y);
    q.z = 16'(z);
    quat_pending.push_back(q);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // driver: holds a word until taken, with random idle bursts between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        yaw_expected.push_back(yaw_from_quat(quat_pending.pop_front()));
        words_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // word still waiting: hold it
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (quat_pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        in_gap = $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= quat_pending[0];
      end
    end
  end

  // monitor: compares each output word with the oldest prediction
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (yaw_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected word yaw=%0d", $signed(out_tdata)));
        end else begin
          want = yaw_expected.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("word %0d yaw=%0d want %0d",
                                      words_seen, $signed(out_tdata), want));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[quaternion_to_yaw_degrees_core] ERROR");
      $finish;
    end
  end

  initial begin
    int kind, a, b;
    // directed corners
    add_quat(0, 0, 0, 0);                  // zero num, positive den
    add_quat(16384, 0, 0, 0);              // identity
    add_quat(0, 0, 0, 16384);              // zero num, negative den
    add_quat(0, 0, 8192, 8192);            // both arguments zero
    add_quat(100, 0, 8192, 8192);          // zero den, positive num
    add_quat(-100, 0, 8192, 8192);         // zero den, negative num
    add_quat(11585, 0, 0, 11585);          // about 90 deg
    add_quat(0, 16384, 0, 0);
    add_quat(0, 0, 16384, 0);
    add_quat(1, 0, 0, 16384);              // negative den, tiny positive num
    add_quat(-1, 0, 0, 16384);             // negative den, tiny negative num
    add_quat(16384, 0, 0, -1);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(32767, 0, 0, -32768);
    add_quat(0, 32767, 32767, 0);
    add_quat(0, -32768, 32767, 0);
    add_quat(11585, 11585, 0, 0);
    // random: full range, components within +/-1.0, zero numerator, tiny
    for (int n = 0; n < RAND_WORDS; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        add_quat($urandom, $urandom, $urandom, $urandom);
      end else if (kind < 8) begin
        add_quat(int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384);
      end else if (kind == 8) begin
        a = $urandom;
        b = $urandom;
        if ($urandom_range(0, 1) == 0)
          add_quat(0, $urandom, 0, b);     // wz + xy = 0
        else
          add_quat(a, 0, $urandom, 0);
      end else begin
        add_quat(int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64,
                 int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64);
      end
    end
    total_words = quat_pending.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < total_words || yaw_expected.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (mismatches == 0) begin
      $display("[quaternion_to_yaw_degrees_core] OK");
    end else begin
      $display("[quaternion_to_yaw_degrees_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/qtyd_pkg.sv
hdl/qtyd_prep.sv
hdl/qtyd_cordic_cell.sv
hdl/qtyd_round.sv
hdl/quaternion_to_yaw_degrees_core.sv
bench/tb_top.sv
